FILE: rtl/line_rasterizer_unit_defines.svh
// Assertion macros for the line rasterizer.
`ifndef LINE_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LRAS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lras: invariant violated");
`define LRAS_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lras: sequence violated");
`else
`define LRAS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define LRAS_ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

FILE: rtl/lras_pkg.sv
package lras_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } lras_op_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } lras_cmd_t;

endpackage

FILE: rtl/line_rasterizer_unit.sv
// Bresenham line rasterizer. A start transfer (tuser 0) loads two endpoints and yields no
// pixel; each step transfer (tuser 1) yields one pixel, tlast on the final one, and a step
// with no line loaded yields nothing. The front stage decodes a transfer and does the line
// setup combinationally, a two-entry queue decouples it from the back stage, and the back
// stage walks the line with one error update per cycle, so the block sustains one transfer
// per clock while m_tready is high; a step passes a queue slot and then the output register.
`include "line_rasterizer_unit_defines.svh"

module line_rasterizer_unit
    import lras_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // x_start, y_start, x_end, y_end
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic m_tlast
);

    localparam int S_W     = ((4 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_W     = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int ENTRY_W = 6 * COORD_WIDTH + 9;

    logic [ENTRY_W-1:0]     entry, head_data;
    logic                   full, head_valid, pop, push;
    logic [1:0]             q_level;
    logic [COORD_WIDTH-1:0] pixel_x, pixel_y;

    assign s_tready = !full;
    assign push     = s_tvalid && s_tready;
    assign m_tdata  = M_W'({pixel_y, pixel_x});

    lras_front #(
        .CW(COORD_WIDTH), .ENTRY_W(ENTRY_W), .S_W(S_W)
    ) u_front (
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .entry  (entry)
    );

    lras_queue #(
        .W(ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_data (head_data),
        .level     (q_level)
    );

    lras_back #(
        .CW(COORD_WIDTH), .ENTRY_W(ENTRY_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_data (head_data),
        .pop       (pop),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last_pixel(m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    `LRAS_ASSERT_ALWAYS(a_queue_bound, aclk, aresetn, q_level != 2'd3)
    `LRAS_ASSERT_ALWAYS(a_pop_needs_entry, aclk, aresetn, !pop || q_level != 2'd0)
    `LRAS_ASSERT_NEXT(a_reset_clears_out, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

FILE: rtl/lras_front.sv
module lras_front
    import lras_pkg::*;
#(
    parameter int CW      = 12,
    parameter int ENTRY_W = 6 * 12 + 9,
    parameter int S_W     = 48
) (
    input  logic [S_W-1:0]     s_tdata,
    input  logic               s_tuser,
    output logic [ENTRY_W-1:0] entry
);

    typedef struct packed {
        lras_cmd_t       kind;
        logic [CW-1:0]   x1;
        logic [CW-1:0]   y1;
        logic            neg;
        logic            majx;
        logic [CW:0]     min2;
        logic [CW:0]     maj2;
        logic [CW+2:0]   err;
        logic [CW:0]     count;
    } lras_entry_t;

    logic [CW-1:0]        xa, ya, xb, yb;
    logic [CW-1:0]        x1, y1, x2, y2;
    logic signed [CW:0]   x1e, y1e, x2e, y2e;
    logic signed [CW:0]   dxw, dyw;
    logic [CW-1:0]        adx, dy, maj, mn;
    logic                 swap, neg, majx;
    lras_entry_t          e;

    always_comb begin
        xa   = s_tdata[CW-1:0];
        ya   = s_tdata[2*CW-1:CW];
        xb   = s_tdata[3*CW-1:2*CW];
        yb   = s_tdata[4*CW-1:3*CW];
        swap = $signed(yb) < $signed(ya);
        x1   = swap ? xb : xa;
        y1   = swap ? yb : ya;
        x2   = swap ? xa : xb;
        y2   = swap ? ya : yb;
        x1e  = {x1[CW-1], x1};
        y1e  = {y1[CW-1], y1};
        x2e  = {x2[CW-1], x2};
        y2e  = {y2[CW-1], y2};
        dxw  = x2e - x1e;
        dyw  = y2e - y1e;
        neg  = dxw[CW];
        adx  = neg ? CW'(-dxw) : dxw[CW-1:0];
        dy   = dyw[CW-1:0];
        majx = adx >= dy;
        maj  = majx ? adx : dy;
        mn   = majx ? dy : adx;

        e.kind  = (lras_op_t'(s_tuser) == OP_START) ? CMD_LOAD : CMD_STEP;
        e.x1    = x1;
        e.y1    = y1;
        e.neg   = neg;
        e.majx  = majx;
        e.min2  = {mn, 1'b0};
        e.maj2  = {maj, 1'b0};
        e.err   = {2'b00, mn, 1'b0} - {3'b000, maj} + {{(CW+2){1'b0}}, majx};
        e.count = {1'b0, maj} + {{CW{1'b0}}, 1'b1};
        entry   = e;
    end

endmodule

FILE: rtl/lras_queue.sv
module lras_queue #(
    parameter int W = 81
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data,
    output logic [1:0]   level
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   level_reg, level_next;

    assign full       = level_reg == 2'd2;
    assign head_valid = level_reg != 2'd0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/lras_back.sv
module lras_back
    import lras_pkg::*;
#(
    parameter int CW      = 12,
    parameter int ENTRY_W = 6 * 12 + 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  logic [ENTRY_W-1:0] head_data,
    output logic               pop,
    output logic [CW-1:0]      pixel_x,
    output logic [CW-1:0]      pixel_y,
    output logic               last_pixel,
    output logic               out_valid,
    input  logic               out_ready
);

    typedef struct packed {
        lras_cmd_t       kind;
        logic [CW-1:0]   x1;
        logic [CW-1:0]   y1;
        logic            neg;
        logic            majx;
        logic [CW:0]     min2;
        logic [CW:0]     maj2;
        logic [CW+2:0]   err;
        logic [CW:0]     count;
    } lras_entry_t;

    lras_entry_t   head;
    logic          active_reg, active_next;
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [CW+2:0] err_reg, err_next;
    logic [CW:0]   left_reg, left_next;
    logic          neg_reg, neg_next, majx_reg, majx_next;
    logic [CW:0]   min2_reg, min2_next, maj2_reg, maj2_next;
    logic          ovalid_reg, ovalid_next;
    logic [CW-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic          olast_reg, olast_next;
    logic          out_free, emit, load, minor;
    logic [CW-1:0] cx_stepped;

    assign head       = lras_entry_t'(head_data);
    assign out_free   = !ovalid_reg || out_ready;
    assign pop        = head_valid && (head.kind == CMD_LOAD || !active_reg || out_free);
    assign load       = pop && head.kind == CMD_LOAD;
    assign emit       = pop && head.kind == CMD_STEP && active_reg;
    assign minor      = !err_reg[CW+2] && err_reg != '0;
    assign cx_stepped = neg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;

    assign pixel_x    = ox_reg;
    assign pixel_y    = oy_reg;
    assign last_pixel = olast_reg;
    assign out_valid  = ovalid_reg;

    always_comb begin
        active_next = active_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        err_next    = err_reg;
        left_next   = left_reg;
        neg_next    = neg_reg;
        majx_next   = majx_reg;
        min2_next   = min2_reg;
        maj2_next   = maj2_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        olast_next  = olast_reg;
        if (load) begin
            active_next = 1'b1;
            cx_next     = head.x1;
            cy_next     = head.y1;
            err_next    = head.err;
            left_next   = head.count;
            neg_next    = head.neg;
            majx_next   = head.majx;
            min2_next   = head.min2;
            maj2_next   = head.maj2;
        end else if (emit) begin
            ovalid_next = 1'b1;
            ox_next     = cx_reg;
            oy_next     = cy_reg;
            olast_next  = left_reg == {{CW{1'b0}}, 1'b1};
            err_next    = err_reg - (minor ? {2'b00, maj2_reg} : '0) + {2'b00, min2_reg};
            if (majx_reg) begin
                cx_next = cx_stepped;
                cy_next = minor ? cy_reg + 1'b1 : cy_reg;
            end else begin
                cy_next = cy_reg + 1'b1;
                cx_next = minor ? cx_stepped : cx_reg;
            end
            left_next   = left_reg - 1'b1;
            active_next = left_reg != {{CW{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            err_reg    <= '0;
            left_reg   <= '0;
            neg_reg    <= 1'b0;
            majx_reg   <= 1'b0;
            min2_reg   <= '0;
            maj2_reg   <= '0;
        end else begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            err_reg    <= err_next;
            left_reg   <= left_next;
            neg_reg    <= neg_next;
            majx_reg   <= majx_next;
            min2_reg   <= min2_next;
            maj2_reg   <= maj2_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        olast_reg <= olast_next;
    end

endmodule
